// ----- rtl/lavm_pkg.sv -----
package lavm_pkg;

    localparam int WORD_W   = 32;
    localparam int COL_W    = 2;
    localparam int NUM_ENT  = 16;

    localparam logic [COL_W-1:0] FIRST_COL = 2'd0;
    localparam logic [COL_W-1:0] LAST_COL  = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef logic [NUM_ENT-1:0][WORD_W-1:0] mat_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } mat_ctl_t;

endpackage

// ----- rtl/look_at_view_matrix_core.sv -----
// Look-at view matrix core.
// Command channel: present eye, target and up (signed fixed point with
// FRAC_BITS fraction bits) with start; the transaction is taken on a rising
// edge where start is high and busy is low. busy rises after each
// transaction, and no new transaction is taken until it falls again.
// Result channel: four column transactions per command, column 0 to 3 in
// consecutive cycles, each shown for one cycle with result_valid high;
// last_column marks column 3, degenerate flags a null forward or side vector.
// Column 0 follows the command through two normalize units, each holding an
// eight-stage square root pipeline and a radix-2 divider at four bits a stage.
// The busy spacing keeps the four columns of one matrix on the result port
// clear of the next. Results cannot be stalled; the receiver takes each
// column as shown. Reset clears all valid bits and busy; commands in flight
// are dropped.
module look_at_view_matrix_core
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] eye_x,
    input  logic [WORD_W-1:0] eye_y,
    input  logic [WORD_W-1:0] eye_z,
    input  logic [WORD_W-1:0] target_x,
    input  logic [WORD_W-1:0] target_y,
    input  logic [WORD_W-1:0] target_z,
    input  logic [WORD_W-1:0] up_x,
    input  logic [WORD_W-1:0] up_y,
    input  logic [WORD_W-1:0] up_z,
    output logic              result_valid,
    output logic [COL_W-1:0]  column_index,
    output logic [WORD_W-1:0] row0_value,
    output logic [WORD_W-1:0] row1_value,
    output logic [WORD_W-1:0] row2_value,
    output logic [WORD_W-1:0] row3_value,
    output logic              last_column,
    output logic              degenerate
);

    localparam int QW   = FRAC_BITS + 2;
    localparam int DW   = WORD_W + 1;
    localparam int CXW  = QW + WORD_W + 1;
    localparam int S1_W = 6 * WORD_W;
    localparam int S2_W = 3 * WORD_W + 3 * QW + 1;

    // command accept and spacing
    logic             accept;
    logic [COL_W-1:0] cnt_reg;
    logic [COL_W-1:0] cnt_next;

    assign accept = start && !busy;
    assign busy   = (cnt_reg != FIRST_COL);

    always_comb
    begin
        if (accept)
        begin
            cnt_next = LAST_COL;
        end
        else if (cnt_reg != FIRST_COL)
        begin
            cnt_next = cnt_reg - COL_W'(1);
        end
        else
        begin
            cnt_next = FIRST_COL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= FIRST_COL;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // input stage: forward difference
    logic                     in_valid_reg;
    logic signed [WORD_W-1:0] eye_reg [3];
    logic signed [WORD_W-1:0] up_reg  [3];
    logic [DW-1:0]            dmag_reg [3];
    logic [2:0]               dneg_reg;
    logic signed [WORD_W-1:0] eye_in [3];
    logic signed [WORD_W-1:0] tgt_in [3];
    logic signed [DW-1:0]     d [3];

    always_comb
    begin
        eye_in[0] = eye_x;
        eye_in[1] = eye_y;
        eye_in[2] = eye_z;
        tgt_in[0] = target_x;
        tgt_in[1] = target_y;
        tgt_in[2] = target_z;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = DW'(tgt_in[i]) - DW'(eye_in[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg   <= eye_in;
        up_reg[0] <= up_x;
        up_reg[1] <= up_y;
        up_reg[2] <= up_z;
        for (int i = 0; i < 3; i++)
        begin
            dneg_reg[i] <= d[i][DW-1];
            dmag_reg[i] <= d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
        end
    end

    // forward normalize
    logic                 f_valid;
    logic signed [QW-1:0] f_q [3];
    logic                 f_nz;
    logic [S1_W-1:0]      f_side;

    lavm_norm #(
        .IN_W   (DW),
        .FB     (FRAC_BITS),
        .SIDE_W (S1_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_mag    (dmag_reg),
        .in_neg    (dneg_reg),
        .in_side   ({eye_reg[0], eye_reg[1], eye_reg[2], up_reg[0], up_reg[1], up_reg[2]}),
        .out_valid (f_valid),
        .out_q     (f_q),
        .out_nz    (f_nz),
        .out_side  (f_side)
    );

    logic signed [WORD_W-1:0] f_eye [3];
    logic signed [WORD_W-1:0] f_up  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f_eye[i] = f_side[S1_W-1-WORD_W*i -: WORD_W];
            f_up[i]  = f_side[3*WORD_W-1-WORD_W*i -: WORD_W];
        end
    end

    // cross product forward x up
    logic                        x_valid_reg;
    logic signed [QW+WORD_W-1:0] xp_reg [6];
    logic signed [QW-1:0]        x_f_reg [3];
    logic signed [WORD_W-1:0]    x_eye_reg [3];
    logic                        x_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
        end
        else
        begin
            x_valid_reg <= f_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        xp_reg[0] <= f_q[1] * f_up[2];
        xp_reg[1] <= f_q[2] * f_up[1];
        xp_reg[2] <= f_q[2] * f_up[0];
        xp_reg[3] <= f_q[0] * f_up[2];
        xp_reg[4] <= f_q[0] * f_up[1];
        xp_reg[5] <= f_q[1] * f_up[0];
        x_f_reg   <= f_q;
        x_eye_reg <= f_eye;
        x_nz_reg  <= f_nz;
    end

    logic                     y_valid_reg;
    logic [CXW-1:0]           ymag_reg [3];
    logic [2:0]               yneg_reg;
    logic signed [QW-1:0]     y_f_reg [3];
    logic signed [WORD_W-1:0] y_eye_reg [3];
    logic                     y_nz_reg;
    logic signed [CXW-1:0]    cx [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cx[i] = CXW'(xp_reg[2*i]) - CXW'(xp_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else
        begin
            y_valid_reg <= x_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            yneg_reg[i] <= cx[i][CXW-1];
            ymag_reg[i] <= cx[i][CXW-1] ? CXW'(-cx[i]) : CXW'(cx[i]);
        end
        y_f_reg   <= x_f_reg;
        y_eye_reg <= x_eye_reg;
        y_nz_reg  <= x_nz_reg;
    end

    // side normalize
    logic                 s_valid;
    logic signed [QW-1:0] s_q [3];
    logic                 s_nz;
    logic [S2_W-1:0]      s_side;

    lavm_norm #(
        .IN_W   (CXW),
        .FB     (FRAC_BITS),
        .SIDE_W (S2_W)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (y_valid_reg),
        .in_mag    (ymag_reg),
        .in_neg    (yneg_reg),
        .in_side   ({y_eye_reg[0], y_eye_reg[1], y_eye_reg[2],
                     y_f_reg[0], y_f_reg[1], y_f_reg[2], y_nz_reg}),
        .out_valid (s_valid),
        .out_q     (s_q),
        .out_nz    (s_nz),
        .out_side  (s_side)
    );

    logic signed [WORD_W-1:0] s_eye [3];
    logic signed [QW-1:0]     s_f   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_eye[i] = s_side[S2_W-1-WORD_W*i -: WORD_W];
            s_f[i]   = s_side[3*QW-QW*i -: QW];
        end
    end

    // basis, translation and column output
    mat_ctl_t b_ctl;
    mat_t     b_mat;

    lavm_basis #(
        .FB (FRAC_BITS)
    ) u_basis (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_valid),
        .s        (s_q),
        .f        (s_f),
        .eye      (s_eye),
        .ok       (s_nz && s_side[0]),
        .ctl      (b_ctl),
        .mat      (b_mat)
    );

    lavm_col_out u_col_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (b_ctl),
        .mat          (b_mat),
        .result_valid (result_valid),
        .column_index (column_index),
        .row0_value   (row0_value),
        .row1_value   (row1_value),
        .row2_value   (row2_value),
        .row3_value   (row3_value),
        .last_column  (last_column),
        .degenerate   (degenerate)
    );

endmodule

// ----- rtl/lavm_norm.sv -----
module lavm_norm
#(
    parameter int IN_W   = 33,
    parameter int FB     = 16,
    parameter int SIDE_W = 1,
    localparam int QW    = FB + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      in_mag [3],
    input  logic [2:0]           in_neg,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [QW-1:0] out_q [3],
    output logic                 out_nz,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int PW    = $clog2(IN_W);
    localparam int MW    = 31;
    localparam int SQ_K  = 4;
    localparam int SQ_ST = 32 / SQ_K;
    localparam int DI    = FB + 1;
    localparam int DK    = 4;
    localparam int DST   = (DI + DK - 1) / DK;
    localparam int NW    = MW + FB + 1;
    localparam int CW    = SIDE_W + 4;

    // stage a: leading one
    logic [IN_W-1:0] orv;
    logic [PW-1:0]   pos;
    logic            a_valid_reg;
    logic [IN_W-1:0] a_mag_reg [3];
    logic [PW-1:0]   a_pos_reg;
    logic [CW-1:0]   a_car_reg;

    always_comb
    begin
        orv = in_mag[0] | in_mag[1] | in_mag[2];
        pos = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (orv[i])
            begin
                pos = PW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= in_mag;
        a_pos_reg <= pos;
        a_car_reg <= {(|orv), in_neg, in_side};
    end

    // stage b: align largest magnitude to bit 30
    logic            b_valid_reg;
    logic [MW-1:0]   b_mag_next [3];
    logic [MW-1:0]   b_mag_reg  [3];
    logic [CW-1:0]   b_car_reg;
    logic [IN_W-1:0] shv [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (a_pos_reg > PW'(MW - 1))
            begin
                shv[i] = a_mag_reg[i] >> (a_pos_reg - PW'(MW - 1));
            end
            else
            begin
                shv[i] = a_mag_reg[i] << (PW'(MW - 1) - a_pos_reg);
            end
            b_mag_next[i] = shv[i][MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_mag_reg <= b_mag_next;
        b_car_reg <= a_car_reg;
    end

    // stage c: squares
    logic            c_valid_reg;
    logic [2*MW-1:0] c_sq_reg  [3];
    logic [MW-1:0]   c_mag_reg [3];
    logic [CW-1:0]   c_car_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_sq_reg[i] <= b_mag_reg[i] * b_mag_reg[i];
        end
        c_mag_reg <= b_mag_reg;
        c_car_reg <= b_car_reg;
    end

    // square root pipeline, entry 0 holds the sum of squares
    logic          sq_valid_reg [0:SQ_ST];
    logic [63:0]   sq_x_reg     [0:SQ_ST];
    logic [31:0]   sq_root_reg  [0:SQ_ST];
    logic [33:0]   sq_rem_reg   [0:SQ_ST];
    logic [MW-1:0] sq_mag_reg   [0:SQ_ST][3];
    logic [CW-1:0] sq_car_reg   [0:SQ_ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg[0]    <= 64'(c_sq_reg[0]) + 64'(c_sq_reg[1]) + 64'(c_sq_reg[2]);
        sq_root_reg[0] <= '0;
        sq_rem_reg[0]  <= '0;
        sq_mag_reg[0]  <= c_mag_reg;
        sq_car_reg[0]  <= c_car_reg;
    end

    for (genvar st = 0; st < SQ_ST; st++)
    begin : g_sqrt
        logic [63:0] x_next;
        logic [31:0] root_next;
        logic [33:0] rem_next;
        logic [35:0] acc;
        logic [35:0] trial;

        always_comb
        begin
            x_next    = sq_x_reg[st];
            root_next = sq_root_reg[st];
            rem_next  = sq_rem_reg[st];
            acc       = '0;
            trial     = '0;
            for (int k = 0; k < SQ_K; k++)
            begin
                acc    = {rem_next, x_next[63:62]};
                trial  = {2'b00, root_next, 2'b01};
                x_next = {x_next[61:0], 2'b00};
                if (acc >= trial)
                begin
                    rem_next  = 34'(acc - trial);
                    root_next = {root_next[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = acc[33:0];
                    root_next = {root_next[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[st+1] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[st+1] <= sq_valid_reg[st];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_x_reg[st+1]    <= x_next;
            sq_root_reg[st+1] <= root_next;
            sq_rem_reg[st+1]  <= rem_next;
            sq_mag_reg[st+1]  <= sq_mag_reg[st];
            sq_car_reg[st+1]  <= sq_car_reg[st];
        end
    end

    // divider pipeline, entry 0 holds the rounded numerator split
    logic          dv_valid_reg [0:DST];
    logic [31:0]   dv_rem_reg   [0:DST][3];
    logic [DI-1:0] dv_low_reg   [0:DST][3];
    logic [DI-1:0] dv_q_reg     [0:DST][3];
    logic [31:0]   dv_len_reg   [0:DST];
    logic [CW-1:0] dv_car_reg   [0:DST];
    logic [NW-1:0] num [3];
    logic [31:0]   len;

    always_comb
    begin
        len = sq_root_reg[SQ_ST];
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {1'b0, sq_mag_reg[SQ_ST][i], {FB{1'b0}}} + NW'(len[31:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= 32'(num[i][NW-1:DI]);
            dv_low_reg[0][i] <= num[i][DI-1:0];
            dv_q_reg[0][i]   <= '0;
        end
        dv_len_reg[0] <= len;
        dv_car_reg[0] <= sq_car_reg[SQ_ST];
    end

    for (genvar st = 0; st < DST; st++)
    begin : g_div
        logic [31:0]   rem_next [3];
        logic [DI-1:0] low_next [3];
        logic [DI-1:0] q_next   [3];
        logic [32:0]   acc;

        always_comb
        begin
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = dv_rem_reg[st][i];
                low_next[i] = dv_low_reg[st][i];
                q_next[i]   = dv_q_reg[st][i];
                for (int k = 0; k < DK; k++)
                begin
                    if (st * DK + k < DI)
                    begin
                        acc         = {rem_next[i], low_next[i][DI-1]};
                        low_next[i] = low_next[i] << 1;
                        if (acc >= {1'b0, dv_len_reg[st]})
                        begin
                            rem_next[i] = 32'(acc - {1'b0, dv_len_reg[st]});
                            q_next[i]   = {q_next[i][DI-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next[i] = acc[31:0];
                            q_next[i]   = {q_next[i][DI-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[st+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[st+1] <= dv_valid_reg[st];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[st+1] <= rem_next;
            dv_low_reg[st+1] <= low_next;
            dv_q_reg[st+1]   <= q_next;
            dv_len_reg[st+1] <= dv_len_reg[st];
            dv_car_reg[st+1] <= dv_car_reg[st];
        end
    end

    // output: apply sign, zero on null vector
    logic                 o_valid_reg;
    logic signed [QW-1:0] o_q_next [3];
    logic signed [QW-1:0] o_q_reg  [3];
    logic [CW-1:0]        o_car_reg;
    logic [CW-1:0]        fin_car;
    logic signed [QW-1:0] qext;

    always_comb
    begin
        fin_car = dv_car_reg[DST];
        qext    = '0;
        for (int i = 0; i < 3; i++)
        begin
            qext = $signed(QW'(dv_q_reg[DST][i]));
            if (!fin_car[CW-1])
            begin
                o_q_next[i] = '0;
            end
            else if (fin_car[SIDE_W+i])
            begin
                o_q_next[i] = -qext;
            end
            else
            begin
                o_q_next[i] = qext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= dv_valid_reg[DST];
        end
    end

    always_ff @(posedge clk)
    begin
        o_q_reg   <= o_q_next;
        o_car_reg <= fin_car;
    end

    assign out_valid = o_valid_reg;
    assign out_q     = o_q_reg;
    assign out_nz    = o_car_reg[CW-1];
    assign out_side  = o_car_reg[SIDE_W-1:0];

endmodule

// ----- rtl/lavm_basis.sv -----
module lavm_basis
    import lavm_pkg::*;
#(
    parameter int FB = 16,
    localparam int QW = FB + 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [QW-1:0]     s [3],
    input  logic signed [QW-1:0]     f [3],
    input  logic signed [WORD_W-1:0] eye [3],
    input  logic                     ok,
    output mat_ctl_t                 ctl,
    output mat_t                     mat
);

    localparam int UW = QW + 1;
    localparam int PW = 2 * QW;
    localparam int EW = QW + WORD_W;
    localparam int SW = QW + 36;
    localparam logic signed [PW:0]   UHALF = 1 << (FB - 1);
    localparam logic signed [SW-1:0] SHALF = 1 << (FB - 1);

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [SW-1:0] v);
        logic [SW-WORD_W:0] top;
        top = v[SW-1:WORD_W-1];
        if (top == '0 || top == '1)
        begin
            return v[WORD_W-1:0];
        end
        return v[SW-1] ? WORD_MIN : WORD_MAX;
    endfunction

    // stage 1: products
    logic                     p_valid_reg;
    logic signed [PW-1:0]     sf_reg [6];
    logic signed [EW-1:0]     se_reg [3];
    logic signed [EW-1:0]     fe_reg [3];
    logic signed [QW-1:0]     p_s_reg [3];
    logic signed [QW-1:0]     p_f_reg [3];
    logic signed [WORD_W-1:0] p_eye_reg [3];
    logic                     p_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sf_reg[0] <= s[1] * f[2];
        sf_reg[1] <= s[2] * f[1];
        sf_reg[2] <= s[2] * f[0];
        sf_reg[3] <= s[0] * f[2];
        sf_reg[4] <= s[0] * f[1];
        sf_reg[5] <= s[1] * f[0];
        for (int i = 0; i < 3; i++)
        begin
            se_reg[i] <= s[i] * eye[i];
            fe_reg[i] <= f[i] * eye[i];
        end
        p_s_reg   <= s;
        p_f_reg   <= f;
        p_eye_reg <= eye;
        p_ok_reg  <= ok;
    end

    // stage 2: true up vector, side and forward dot sums
    logic                     q_valid_reg;
    logic signed [UW-1:0]     u_next [3];
    logic signed [UW-1:0]     u_reg  [3];
    logic signed [SW-1:0]     sdot_reg;
    logic signed [SW-1:0]     fdot_reg;
    logic signed [QW-1:0]     q_s_reg [3];
    logic signed [QW-1:0]     q_f_reg [3];
    logic signed [WORD_W-1:0] q_eye_reg [3];
    logic                     q_ok_reg;
    logic signed [PW:0]       ud [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ud[i]     = (PW+1)'(sf_reg[2*i]) - (PW+1)'(sf_reg[2*i+1]) + UHALF;
            u_next[i] = UW'(ud[i] >>> FB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        sdot_reg  <= SW'(se_reg[0]) + SW'(se_reg[1]) + SW'(se_reg[2]);
        fdot_reg  <= SW'(fe_reg[0]) + SW'(fe_reg[1]) + SW'(fe_reg[2]);
        q_s_reg   <= p_s_reg;
        q_f_reg   <= p_f_reg;
        q_eye_reg <= p_eye_reg;
        q_ok_reg  <= p_ok_reg;
    end

    // stage 3: up dot products, x and z translation
    logic                     r_valid_reg;
    logic signed [UW+WORD_W-1:0] ue_reg [3];
    logic [WORD_W-1:0]        tx_reg;
    logic [WORD_W-1:0]        tz_reg;
    logic signed [QW-1:0]     r_s_reg [3];
    logic signed [QW-1:0]     r_f_reg [3];
    logic signed [UW-1:0]     r_u_reg [3];
    logic                     r_ok_reg;
    logic signed [SW-1:0]     rs;
    logic signed [SW-1:0]     rf;

    always_comb
    begin
        rs = (sdot_reg + SHALF) >>> FB;
        rf = (fdot_reg + SHALF) >>> FB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ue_reg[i] <= u_reg[i] * q_eye_reg[i];
        end
        tx_reg   <= sat_word(-rs);
        tz_reg   <= sat_word(rf);
        r_s_reg  <= q_s_reg;
        r_f_reg  <= q_f_reg;
        r_u_reg  <= u_reg;
        r_ok_reg <= q_ok_reg;
    end

    // stage 4: y translation, assemble matrix
    logic signed [SW-1:0] udot;
    logic signed [SW-1:0] ru;
    mat_t                 mat_next;
    mat_t                 mat_reg;
    mat_ctl_t             ctl_reg;

    always_comb
    begin
        udot     = SW'(ue_reg[0]) + SW'(ue_reg[1]) + SW'(ue_reg[2]);
        ru       = (udot + SHALF) >>> FB;
        mat_next = '0;
        if (r_ok_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mat_next[4*i+0] = WORD_W'(r_s_reg[i]);
                mat_next[4*i+1] = WORD_W'(r_u_reg[i]);
                mat_next[4*i+2] = -WORD_W'(r_f_reg[i]);
            end
            mat_next[12] = tx_reg;
            mat_next[13] = sat_word(-ru);
            mat_next[14] = tz_reg;
            mat_next[15] = WORD_W'(1) << FB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= r_valid_reg;
            ctl_reg.ok    <= r_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign ctl = ctl_reg;
    assign mat = mat_reg;

endmodule

// ----- rtl/lavm_col_out.sv -----
module lavm_col_out
    import lavm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mat_ctl_t          ctl,
    input  mat_t              mat,
    output logic              result_valid,
    output logic [COL_W-1:0]  column_index,
    output logic [WORD_W-1:0] row0_value,
    output logic [WORD_W-1:0] row1_value,
    output logic [WORD_W-1:0] row2_value,
    output logic [WORD_W-1:0] row3_value,
    output logic              last_column,
    output logic              degenerate
);

    mat_t              hold_reg;
    logic              hold_deg_reg;
    logic              act_reg;
    logic [COL_W-1:0]  cnt_reg;
    logic              valid_reg;
    logic [COL_W-1:0]  col_reg;
    logic [WORD_W-1:0] row_reg [4];
    logic              last_reg;
    logic              deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            cnt_reg   <= FIRST_COL;
            valid_reg <= 1'b0;
        end
        else if (ctl.valid)
        begin
            act_reg   <= 1'b1;
            cnt_reg   <= FIRST_COL + COL_W'(1);
            valid_reg <= 1'b1;
        end
        else if (act_reg)
        begin
            act_reg   <= (cnt_reg != LAST_COL);
            cnt_reg   <= cnt_reg + COL_W'(1);
            valid_reg <= 1'b1;
        end
        else
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            hold_reg     <= mat;
            hold_deg_reg <= !ctl.ok;
            col_reg      <= FIRST_COL;
            last_reg     <= 1'b0;
            deg_reg      <= !ctl.ok;
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= mat[{FIRST_COL, COL_W'(r)}];
            end
        end
        else
        begin
            col_reg  <= cnt_reg;
            last_reg <= (cnt_reg == LAST_COL);
            deg_reg  <= hold_deg_reg;
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= hold_reg[{cnt_reg, COL_W'(r)}];
            end
        end
    end

    assign result_valid = valid_reg;
    assign column_index = col_reg;
    assign row0_value   = row_reg[0];
    assign row1_value   = row_reg[1];
    assign row2_value   = row_reg[2];
    assign row3_value   = row_reg[3];
    assign last_column  = last_reg;
    assign degenerate   = deg_reg;

endmodule

// ----- rtl/lavm_checker.sv -----
module lavm_checker
    import lavm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input logic [COL_W-1:0]  column_index,
    input logic [WORD_W-1:0] row0_value,
    input logic [WORD_W-1:0] row1_value,
    input logic [WORD_W-1:0] row2_value,
    input logic [WORD_W-1:0] row3_value,
    input logic              last_column,
    input logic              degenerate
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command transaction");

    a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_column |=>
            result_valid && column_index == $past(column_index) + COL_W'(1))
        else $error("result columns not consecutive");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> last_column == (column_index == LAST_COL))
        else $error("last_column mark does not match column");

    a_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_column |-> row3_value == '0)
        else $error("bottom row not zero outside translation column");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |->
            row0_value == '0 && row1_value == '0 && row2_value == '0 && row3_value == '0)
        else $error("degenerate transaction carries nonzero entries");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (.*);
